### rtl/sofl_pkg.sv
package sofl_pkg;

  localparam int BUF_DEPTH = 32;
  localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

  localparam int BYTE_W = 8;
  localparam int CODE_W = 16;
  localparam int LEN_W  = 6;
  localparam int IDX_W  = 5;

  localparam logic [BYTE_W-1:0] START_BYTE  = 8'h4A;
  localparam logic [LEN_W-1:0]  MAX_LEN_RST = 6'd32;

  typedef enum logic [6:0] {
    PH_WAIT    = 7'b0000001,
    PH_CODE_HI = 7'b0000010,
    PH_CODE_LO = 7'b0000100,
    PH_LEN_HI  = 7'b0001000,
    PH_LEN_LO  = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_CHECK   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic              start;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] sum;
  } frame_info_t;

endpackage

### rtl/sofl_if.sv
interface sofl_in_if;
  import sofl_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sofl_out_if;
  import sofl_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] func_code;
  logic [LEN_W-1:0]  frame_len;
  logic              has_payload;
  logic [IDX_W-1:0]  byte_index;
  logic [BYTE_W-1:0] payload_byte;
  logic [BYTE_W-1:0] check_byte;
  logic              last;

  modport source (output valid, output func_code, output frame_len, output has_payload,
                  output byte_index, output payload_byte, output check_byte, output last,
                  input ready);
  modport sink   (input valid, input func_code, input frame_len, input has_payload,
                  input byte_index, input payload_byte, input check_byte, input last,
                  output ready);
endinterface

### rtl/sof_len_frame_parser_xor_check_core.sv
// Frame parser for a byte stream: start byte 0x4A, 16-bit function code and
// 16-bit length (high byte first), payload, then an XOR check byte over code,
// length and payload.
// in_chan: one received byte per transfer. Bytes are taken one a cycle while
// a frame is being received; payload bytes go into a 32-entry byte RAM.
// out_chan: one transfer per payload byte of a frame whose check byte
// matches, with last on the final one; an empty frame gives a single transfer
// with has_payload low, in the cycle after its check byte is taken.
// After the check byte the first result goes through the drain's active flag,
// the RAM read register and the output register, then one result per cycle
// while out_chan is not stalled; the RAM read port sets that rate. in_chan.ready
// is low after a matching check byte until the last result of the frame is taken.
// A stall on out_chan holds the current result and the RAM read pipeline.
// cfg_we/cfg_wdata set max_len (reset 32, saturates at 32); write only while
// idle. Reset (rst_n, synchronous) returns to hunting for the start byte and
// empties the output; the payload RAM is not cleared.
module sof_len_frame_parser_xor_check_core
  import sofl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  sofl_in_if.sink          in_chan,
  sofl_out_if.source       out_chan,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata
);

  frame_info_t       info;
  logic              busy;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  sofl_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .drain_busy (busy),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .info       (info)
  );

  sofl_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sofl_drain u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .info      (info),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .busy      (busy),
    .out_chan  (out_chan)
  );

`ifndef NO_ASSERTIONS
  a_no_fill_while_drain: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !ram_we)
    else $error("payload write during drain");

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    info.start |=> busy)
    else $error("frame accepted but nothing queued");

  a_empty_frame_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.has_payload) |->
      (out_chan.last && out_chan.frame_len == '0 && out_chan.byte_index == '0))
    else $error("malformed empty-frame result");

  a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.has_payload) |->
      ({1'b0, out_chan.byte_index} < out_chan.frame_len))
    else $error("byte index beyond frame length");
`endif

endmodule

### rtl/sofl_ram.sv
module sofl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/sofl_parser.sv
module sofl_parser
  import sofl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  sofl_in_if.sink           in_chan,
  input  logic              cfg_we,
  input  logic [LEN_W-1:0]  cfg_wdata,
  input  logic              drain_busy,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [BYTE_W-1:0] ram_wdata,
  output frame_info_t       info
);

  phase_t            phase_r, phase_nxt;
  logic [LEN_W-1:0]  max_len_r;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [BYTE_W-1:0] len_hi_r, len_hi_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [CODE_W-1:0] len_full;
  logic [CODE_W-1:0] limit;
  logic [CNT_W-1:0]  fill_inc;
  logic [BYTE_W-1:0] b;
  logic              acc;
  logic              start;

  assign in_chan.ready = !drain_busy;
  assign acc           = in_chan.valid && in_chan.ready;
  assign b             = in_chan.rx_byte;
  assign len_full      = {len_hi_r, b};
  assign limit         = ({10'b0, max_len_r} > CODE_W'(BUF_DEPTH)) ? CODE_W'(BUF_DEPTH)
                                                                   : {10'b0, max_len_r};
  assign fill_inc      = fill_r + CNT_W'(1);

  always_comb begin
    phase_nxt  = phase_r;
    code_nxt   = code_r;
    len_hi_nxt = len_hi_r;
    len_nxt    = len_r;
    fill_nxt   = fill_r;
    sum_nxt    = sum_r;
    ram_we     = 1'b0;
    start      = 1'b0;
    if (acc) begin
      unique case (phase_r)
        PH_CODE_HI: begin
          code_nxt[15:8] = b;
          sum_nxt        = sum_r ^ b;
          phase_nxt      = PH_CODE_LO;
        end
        PH_CODE_LO: begin
          code_nxt[7:0] = b;
          sum_nxt       = sum_r ^ b;
          phase_nxt     = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_hi_nxt = b;
          sum_nxt    = sum_r ^ b;
          phase_nxt  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          sum_nxt  = sum_r ^ b;
          len_nxt  = len_full[LEN_W-1:0];
          fill_nxt = '0;
          if (len_full > limit) begin
            phase_nxt = PH_WAIT;
          end else if (len_full == '0) begin
            phase_nxt = PH_CHECK;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          ram_we   = 1'b1;
          fill_nxt = fill_inc;
          sum_nxt  = sum_r ^ b;
          if (fill_inc >= CNT_W'(len_r)) begin
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          start     = (b == sum_r);
          phase_nxt = PH_WAIT;
        end
        default: begin
          if (b == START_BYTE) begin
            sum_nxt   = '0;
            phase_nxt = PH_CODE_HI;
          end else begin
            phase_nxt = PH_WAIT;
          end
        end
      endcase
    end
  end

  assign ram_waddr  = fill_r[ADDR_W-1:0];
  assign ram_wdata  = b;
  assign info.start = start;
  assign info.code  = code_r;
  assign info.len   = len_r;
  assign info.sum   = sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT;
      max_len_r <= MAX_LEN_RST;
      fill_r    <= '0;
      sum_r     <= '0;
    end else begin
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      sum_r   <= sum_nxt;
      if (cfg_we) begin
        max_len_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    code_r   <= code_nxt;
    len_hi_r <= len_hi_nxt;
    len_r    <= len_nxt;
  end

endmodule

### rtl/sofl_drain.sv
module sofl_drain
  import sofl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  frame_info_t       info,
  output logic              ram_re,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [BYTE_W-1:0] ram_rdata,
  output logic              busy,
  sofl_out_if.source        out_chan
);

  logic              active_r, active_nxt;
  logic              pend_r, pend_nxt;
  logic [CNT_W-1:0]  rd_cnt_r, rd_cnt_nxt;
  logic [ADDR_W-1:0] pend_idx_r;
  logic [CODE_W-1:0] code_r;
  logic [LEN_W-1:0]  len_r;
  logic [BYTE_W-1:0] sum_r;
  logic              ov_r, ov_nxt;
  logic [IDX_W-1:0]  o_idx_r;
  logic [BYTE_W-1:0] o_byte_r;
  logic              o_has_r;
  logic              o_last_r;
  logic              slot_free;
  logic              load;
  logic              empty_frame;

  assign slot_free   = !ov_r || out_chan.ready;
  assign load        = pend_r && slot_free;
  assign empty_frame = info.start && (info.len == '0);
  assign ram_re      = active_r && (!pend_r || load);
  assign ram_raddr   = rd_cnt_r[ADDR_W-1:0];
  assign busy        = active_r || pend_r || ov_r;

  always_comb begin
    active_nxt = active_r;
    rd_cnt_nxt = rd_cnt_r;
    pend_nxt   = pend_r;
    ov_nxt     = ov_r;
    if (out_chan.ready) begin
      ov_nxt = 1'b0;
    end
    if (load || empty_frame) begin
      ov_nxt = 1'b1;
    end
    if (load) begin
      pend_nxt = 1'b0;
    end
    if (ram_re) begin
      pend_nxt   = 1'b1;
      rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
      if (rd_cnt_r + CNT_W'(1) == CNT_W'(len_r)) begin
        active_nxt = 1'b0;
      end
    end
    if (info.start && !empty_frame) begin
      active_nxt = 1'b1;
      rd_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pend_r   <= 1'b0;
      ov_r     <= 1'b0;
      rd_cnt_r <= '0;
    end else begin
      active_r <= active_nxt;
      pend_r   <= pend_nxt;
      ov_r     <= ov_nxt;
      rd_cnt_r <= rd_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (info.start) begin
      code_r <= info.code;
      len_r  <= info.len;
      sum_r  <= info.sum;
    end
    if (ram_re) begin
      pend_idx_r <= rd_cnt_r[ADDR_W-1:0];
    end
    if (empty_frame) begin
      o_has_r  <= 1'b0;
      o_idx_r  <= '0;
      o_byte_r <= '0;
      o_last_r <= 1'b1;
    end else if (load) begin
      o_has_r  <= 1'b1;
      o_idx_r  <= IDX_W'(pend_idx_r);
      o_byte_r <= ram_rdata;
      o_last_r <= (CNT_W'(pend_idx_r) + CNT_W'(1) == CNT_W'(len_r));
    end
  end

  assign out_chan.valid        = ov_r;
  assign out_chan.func_code    = code_r;
  assign out_chan.frame_len    = len_r;
  assign out_chan.has_payload  = o_has_r;
  assign out_chan.byte_index   = o_idx_r;
  assign out_chan.payload_byte = o_byte_r;
  assign out_chan.check_byte   = sum_r;
  assign out_chan.last         = o_last_r;

endmodule

### tb/sof_len_frame_parser_xor_check_core_test.sv
`timescale 1ns / 100ps

module sof_len_frame_parser_xor_check_core_test;
  import sofl_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int FLUSH_BYTES   = 40;

  typedef enum logic [1:0] {OP_BYTE, OP_CFG, OP_DRAIN} op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [BYTE_W-1:0] value;
  } rx_op_t;

  typedef struct packed {
    logic [CODE_W-1:0] func_code;
    logic [LEN_W-1:0]  frame_len;
    logic              has_payload;
    logic [IDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] check_byte;
    logic              last;
  } frame_item_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  sofl_in_if  rx_if ();
  sofl_out_if res_if ();

  sof_len_frame_parser_xor_check_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (rx_if),
    .out_chan  (res_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  rx_op_t      rx_ops[$];
  frame_item_t frame_results[$];

  // parser model state
  phase_t            rx_phase;
  logic [CODE_W-1:0] code_acc;
  logic [15:0]       len_acc;
  int                fill_cnt;
  logic [BYTE_W-1:0] sum_acc;
  logic [BYTE_W-1:0] stored_bytes [BUF_DEPTH];
  logic [LEN_W-1:0]  max_len_q;

  // stimulus-side view of the limit
  int gen_lim;
  bit gen_dirty;

  int   err_cnt;
  int   cycle_cnt;
  logic in_taken;
  logic out_taken;
  int   in_gap;
  bit   in_burst;
  int   out_stall;
  bit   out_burst;
  int   settle_cnt;

  logic              nxt_valid;
  logic [BYTE_W-1:0] nxt_byte;
  logic              nxt_we;
  logic [LEN_W-1:0]  nxt_wdata;

  frame_item_t got_item;
  frame_item_t exp_item;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_frame_state();
    rx_phase = PH_WAIT;
    code_acc = '0;
    len_acc  = '0;
    fill_cnt = 0;
    sum_acc  = '0;
  endfunction

  function automatic void parse_rx_byte(logic [BYTE_W-1:0] b);
    frame_item_t r;
    int          lim;
    int          k;
    lim = (max_len_q > BUF_DEPTH) ? BUF_DEPTH : int'(max_len_q);
    case (rx_phase)
      PH_CODE_HI: begin
        code_acc = {b, 8'h00};
        sum_acc ^= b;
        rx_phase = PH_CODE_LO;
      end
      PH_CODE_LO: begin
        code_acc[7:0] = b;
        sum_acc ^= b;
        rx_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_acc = {b, 8'h00};
        sum_acc ^= b;
        rx_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_acc[7:0] = b;
        sum_acc ^= b;
        if (len_acc > lim) begin
          clear_frame_state();
        end else begin
          fill_cnt = 0;
          rx_phase = (len_acc == 0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (fill_cnt < BUF_DEPTH) stored_bytes[fill_cnt] = b;
        fill_cnt++;
        sum_acc ^= b;
        if (fill_cnt >= len_acc) rx_phase = PH_CHECK;
      end
      PH_CHECK: begin
        if (b == sum_acc) begin
          r.func_code  = code_acc;
          r.frame_len  = len_acc[LEN_W-1:0];
          r.check_byte = sum_acc;
          if (len_acc == 0) begin
            r.has_payload  = 1'b0;
            r.byte_index   = '0;
            r.payload_byte = '0;
            r.last         = 1'b1;
            frame_results.push_back(r);
          end else begin
            for (k = 0; k < len_acc && k < BUF_DEPTH; k++) begin
              r.has_payload  = 1'b1;
              r.byte_index   = k[IDX_W-1:0];
              r.payload_byte = stored_bytes[k];
              r.last         = (k + 1 == len_acc);
              frame_results.push_back(r);
            end
          end
        end
        clear_frame_state();
      end
      default: begin
        if (b == START_BYTE) begin
          clear_frame_state();
          rx_phase = PH_CODE_HI;
        end else begin
          rx_phase = PH_WAIT;
        end
      end
    endcase
  endfunction

  function automatic void push_byte(logic [BYTE_W-1:0] b);
    rx_op_t op;
    op.kind  = OP_BYTE;
    op.value = b;
    rx_ops.push_back(op);
  endfunction

  function automatic void push_drain();
    rx_op_t op;
    op.kind  = OP_DRAIN;
    op.value = '0;
    rx_ops.push_back(op);
  endfunction

  // flush a possibly half-parsed frame before touching the limit
  function automatic void push_cfg(logic [LEN_W-1:0] v);
    rx_op_t op;
    int     i;
    if (gen_dirty) begin
      for (i = 0; i < FLUSH_BYTES; i++) push_byte(8'h00);
      gen_dirty = 1'b0;
    end
    op.kind  = OP_CFG;
    op.value = {2'b00, v};
    rx_ops.push_back(op);
    gen_lim = (v > BUF_DEPTH) ? BUF_DEPTH : int'(v);
  endfunction

  function automatic void push_frame(logic [15:0] code, logic [15:0] len, bit bad, int fill);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] pb;
    int                i;
    push_byte(START_BYTE);
    push_byte(code[15:8]);
    push_byte(code[7:0]);
    push_byte(len[15:8]);
    push_byte(len[7:0]);
    sum = code[15:8] ^ code[7:0] ^ len[15:8] ^ len[7:0];
    if (len <= gen_lim) begin
      for (i = 0; i < len; i++) begin
        pb = (fill < 0) ? 8'($urandom) : 8'(fill);
        push_byte(pb);
        sum ^= pb;
      end
      push_byte(bad ? sum ^ 8'($urandom_range(1, 255)) : sum);
    end
  endfunction

  function automatic void build_stimulus();
    int sel;
    int len;
    int n;
    int i;
    int start_size;

    push_byte(8'h00);
    push_byte(8'hFF);
    push_frame(16'hFFFF, 16'd0, 1'b0, -1);
    push_frame(16'h0000, 16'd1, 1'b0, 8'hFF);
    push_frame(16'h1234, 16'd2, 1'b1, -1);
    push_frame(16'h4A00, 16'd0, 1'b0, -1);
    push_frame(16'hA5A5, 16'd3, 1'b0, -1);
    push_frame(16'hABCD, 16'hFFFF, 1'b0, -1);
    push_frame(16'h0102, 16'h0100, 1'b0, -1);
    push_frame(16'h5AC3, 16'd32, 1'b0, 8'hFF);
    push_drain();
    push_cfg(6'd0);
    push_frame(16'h00FF, 16'd0, 1'b0, -1);
    push_frame(16'hFF00, 16'd1, 1'b0, -1);
    push_cfg(6'd63);
    push_frame(16'h3C3C, 16'd32, 1'b0, 8'h00);
    push_frame(16'hC3C3, 16'd33, 1'b0, -1);
    push_cfg(6'd1);
    push_frame(16'h7E81, 16'd1, 1'b0, -1);
    push_cfg(6'd32);

    start_size = rx_ops.size();
    while (rx_ops.size() - start_size < 250) begin
      sel = $urandom_range(0, 99);
      if (sel < 77) begin
        if ($urandom_range(0, 3) == 0) len = $urandom_range(0, gen_lim);
        else len = $urandom_range(0, (gen_lim < 6) ? gen_lim : 6);
        push_frame(16'($urandom), 16'(len), sel >= 65, -1);
      end else if (sel < 83) begin
        if ($urandom_range(0, 1) == 0) len = $urandom_range(gen_lim + 1, 40);
        else len = $urandom_range(gen_lim + 1, 16'hFFFF);
        push_frame(16'($urandom), 16'(len), 1'b0, -1);
      end else if (sel < 91) begin
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) push_byte(8'($urandom));
        gen_dirty = 1'b1;
      end else if (sel < 96) begin
        push_byte(START_BYTE);
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) push_byte(8'($urandom));
        gen_dirty = 1'b1;
      end else if (sel < 98) begin
        push_drain();
      end else begin
        push_cfg(6'($urandom_range(0, 63)));
      end
    end
  endfunction

  // input channel and register port
  always @(negedge clk) begin
    nxt_valid = rx_if.valid;
    nxt_byte  = rx_if.rx_byte;
    nxt_we    = 1'b0;
    nxt_wdata = cfg_wdata;
    if (rst_n) begin
      if (in_taken) nxt_valid = 1'b0;
      if (!nxt_valid && rx_ops.size() > 0) begin
        if (rx_ops[0].kind == OP_BYTE) begin
          settle_cnt = 0;
          if (in_gap > 0) begin
            in_gap--;
          end else begin
            nxt_valid = 1'b1;
            nxt_byte  = rx_ops[0].value;
            void'(rx_ops.pop_front());
            if ($urandom_range(0, 19) == 0) in_burst = !in_burst;
            in_gap = in_burst ? 0 : $urandom_range(0, 16);
          end
        end else if (frame_results.size() != 0) begin
          settle_cnt = 0;
        end else if (settle_cnt < SETTLE_CYCLES) begin
          settle_cnt++;
        end else begin
          if (rx_ops[0].kind == OP_CFG) begin
            nxt_we    = 1'b1;
            nxt_wdata = rx_ops[0].value[LEN_W-1:0];
          end
          void'(rx_ops.pop_front());
          settle_cnt = 0;
        end
      end
    end
    rx_if.valid   <= nxt_valid;
    rx_if.rx_byte <= nxt_byte;
    cfg_we        <= nxt_we;
    cfg_wdata     <= nxt_wdata;
  end

  // result channel back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        if ($urandom_range(0, 19) == 0) out_burst = !out_burst;
        out_stall = out_burst ? 0 : $urandom_range(0, 16);
      end else if (out_stall > 0) begin
        out_stall--;
      end
      res_if.ready <= (out_stall == 0);
    end
  end

  always @(posedge clk) begin
    in_taken  <= rst_n && rx_if.valid && rx_if.ready;
    out_taken <= rst_n && res_if.valid && res_if.ready;
    if (rst_n) begin
      if (cfg_we) max_len_q = cfg_wdata;
      if (rx_if.valid && rx_if.ready) parse_rx_byte(rx_if.rx_byte);
      if (res_if.valid && res_if.ready) begin
        got_item = {res_if.func_code, res_if.frame_len, res_if.has_payload, res_if.byte_index,
                    res_if.payload_byte, res_if.check_byte, res_if.last};
        if (frame_results.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual %p", $time, got_item);
          err_cnt++;
        end else begin
          exp_item = frame_results.pop_front();
          if (got_item !== exp_item) begin
            $display("%0t: mismatch, expected code=%h len=%0d has=%b idx=%0d byte=%h chk=%h last=%b",
                     $time, exp_item.func_code, exp_item.frame_len, exp_item.has_payload,
                     exp_item.byte_index, exp_item.payload_byte, exp_item.check_byte,
                     exp_item.last);
            $display("%0t:          actual   code=%h len=%0d has=%b idx=%0d byte=%h chk=%h last=%b",
                     $time, got_item.func_code, got_item.frame_len, got_item.has_payload,
                     got_item.byte_index, got_item.payload_byte, got_item.check_byte,
                     got_item.last);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, frame_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = '0;
    res_if.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_taken       = 1'b0;
    out_taken      = 1'b0;
    in_gap         = 0;
    in_burst       = 1'b0;
    out_stall      = 0;
    out_burst      = 1'b0;
    settle_cnt     = 0;
    err_cnt        = 0;
    cycle_cnt      = 0;
    max_len_q      = MAX_LEN_RST;
    gen_lim        = BUF_DEPTH;
    gen_dirty      = 1'b0;
    clear_frame_state();
    build_stimulus();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (rx_ops.size() != 0 || rx_if.valid) @(posedge clk);
    while (frame_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (frame_results.size() != 0) begin
      $display("%0t: %0d results expected but never transferred", $time, frame_results.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
